FILE: rtl/core/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// types, widths and codes shared by the segment intersection pipeline
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int CW   = 24;          // coordinate width
    localparam int DFW  = CW + 1;      // coordinate difference
    localparam int PRW  = 2 * DFW;     // product of two differences
    localparam int NW   = PRW + 1;     // determinant and numerators
    localparam int DW   = NW + 1;      // divider magnitudes and remainders
    localparam int PF   = 16;          // fraction bits of t and u
    localparam int QW   = PF + 1;      // quotient magnitude, below two
    localparam int MPW  = QW + DFW;    // t times difference
    localparam int DLW  = MPW - PF;    // truncated offset
    localparam int SW   = DLW + 2;     // offset plus start, signed
    localparam int EPSW = 32;
    localparam int TOLW = 16;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_DET_EPS   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_PARAM_TOL = 2'd1;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_PARALLEL = 2'd1;
    localparam logic [1:0] OUT_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } seg_in_t;

    typedef struct packed {
        logic [1:0]           outcome;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } seg_out_t;

    // state carried through the divider stages
    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [DFW-1:0] dax;
        logic signed [DFW-1:0] day;
        logic [DW-1:0]         d;
        logic [DW-1:0]         rt;
        logic [DW-1:0]         ru;
        logic [QW-1:0]         qt;
        logic [QW-1:0]         qu;
        logic                  neg_t;
        logic                  neg_u;
        logic                  oor_t;
        logic                  oor_u;
        logic                  par;
    } div_t;

endpackage

FILE: rtl/core/line_segment_intersection_top.sv
// ----------------------------------------------------------------------------
// line_segment_intersection_top
// pipeline: one stage each for the differences, products, numerators,
// magnitudes, 17 divider steps, the point multiply and the final add and
// saturate
// throughput: one segment pair per cycle while the output is not stalled, set by the per-stage valid chain
// reset: pipeline empties, det_epsilon returns to 1, param_tolerance to 6554
// ----------------------------------------------------------------------------
module line_segment_intersection_top
    import lsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  seg_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output seg_out_t          out_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [EPSW-1:0]   cfg_data
);

    // stage numbering: 0..3 front, 4..20 divider, 21 point multiply, 22 output
    localparam int NDIV = QW;
    localparam int SPT  = 4 + NDIV;
    localparam int SOUT = SPT + 1;
    localparam int NS   = SOUT + 1;

    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [DFW-1:0] dax;
        logic signed [DFW-1:0] day;
        logic signed [DFW-1:0] dbx;
        logic signed [DFW-1:0] dby;
        logic signed [DFW-1:0] ox;
        logic signed [DFW-1:0] oy;
    } s1_t;

    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [DFW-1:0] dax;
        logic signed [DFW-1:0] day;
        logic signed [PRW-1:0] pda;
        logic signed [PRW-1:0] pdb;
        logic signed [PRW-1:0] pta;
        logic signed [PRW-1:0] ptb;
        logic signed [PRW-1:0] pua;
        logic signed [PRW-1:0] pub;
    } s2_t;

    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [DFW-1:0] dax;
        logic signed [DFW-1:0] day;
        logic signed [NW-1:0]  det;
        logic signed [NW-1:0]  tn;
        logic signed [NW-1:0]  un;
    } s3_t;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [MPW-1:0]       px;
        logic [MPW-1:0]       py;
        logic                 sx;
        logic                 sy;
        logic [1:0]           outcome;
    } pt_t;

    // ---------------- configuration registers
    logic [EPSW-1:0] eps_reg;
    logic [TOLW-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPSW'(1);
            tol_reg <= TOLW'(6554);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DET_EPS:   eps_reg <= cfg_data;
                CFG_PARAM_TOL: tol_reg <= cfg_data[TOLW-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- valid chain, a stage moves when it is empty or its
    // successor moves, so bubbles close up behind a stalled output beat
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic [NS-1:0] vin;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vin[0] = in_valid;
        for (int k = 1; k < NS; k++)
        begin
            vin[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[SOUT];

    // ---------------- stage 0: direction and offset vectors
    s1_t s1_reg;
    s1_t s1_next;

    always_comb
    begin
        s1_next.x1  = in_data.a_start_x;
        s1_next.y1  = in_data.a_start_y;
        s1_next.dax = DFW'(in_data.a_end_x) - DFW'(in_data.a_start_x);
        s1_next.day = DFW'(in_data.a_end_y) - DFW'(in_data.a_start_y);
        s1_next.dbx = DFW'(in_data.b_end_x) - DFW'(in_data.b_start_x);
        s1_next.dby = DFW'(in_data.b_end_y) - DFW'(in_data.b_start_y);
        s1_next.ox  = DFW'(in_data.a_start_x) - DFW'(in_data.b_start_x);
        s1_next.oy  = DFW'(in_data.a_start_y) - DFW'(in_data.b_start_y);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- stage 1: six cross products
    s2_t s2_reg;
    s2_t s2_next;

    always_comb
    begin
        s2_next.x1  = s1_reg.x1;
        s2_next.y1  = s1_reg.y1;
        s2_next.dax = s1_reg.dax;
        s2_next.day = s1_reg.day;
        s2_next.pda = PRW'(s1_reg.dby) * PRW'(s1_reg.dax);
        s2_next.pdb = PRW'(s1_reg.dbx) * PRW'(s1_reg.day);
        s2_next.pta = PRW'(s1_reg.dbx) * PRW'(s1_reg.oy);
        s2_next.ptb = PRW'(s1_reg.dby) * PRW'(s1_reg.ox);
        s2_next.pua = PRW'(s1_reg.dax) * PRW'(s1_reg.oy);
        s2_next.pub = PRW'(s1_reg.day) * PRW'(s1_reg.ox);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // ---------------- stage 2: determinant and both numerators
    s3_t s3_reg;
    s3_t s3_next;

    always_comb
    begin
        s3_next.x1  = s2_reg.x1;
        s3_next.y1  = s2_reg.y1;
        s3_next.dax = s2_reg.dax;
        s3_next.day = s2_reg.day;
        s3_next.det = NW'(s2_reg.pda) - NW'(s2_reg.pdb);
        s3_next.tn  = NW'(s2_reg.pta) - NW'(s2_reg.ptb);
        s3_next.un  = NW'(s2_reg.pua) - NW'(s2_reg.pub);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
    end

    // ---------------- stage 3: magnitudes, parallel test, range precheck
    div_t s4_reg;
    div_t s4_next;
    logic [NW-1:0] ad;
    logic [NW-1:0] amt;
    logic [NW-1:0] amu;

    always_comb
    begin
        ad  = s3_reg.det[NW-1] ? NW'(-s3_reg.det) : NW'(s3_reg.det);
        amt = s3_reg.tn[NW-1]  ? NW'(-s3_reg.tn)  : NW'(s3_reg.tn);
        amu = s3_reg.un[NW-1]  ? NW'(-s3_reg.un)  : NW'(s3_reg.un);
        s4_next.x1    = s3_reg.x1;
        s4_next.y1    = s3_reg.y1;
        s4_next.dax   = s3_reg.dax;
        s4_next.day   = s3_reg.day;
        s4_next.d     = DW'(ad);
        s4_next.rt    = DW'(amt);
        s4_next.ru    = DW'(amu);
        s4_next.qt    = '0;
        s4_next.qu    = '0;
        s4_next.neg_t = s3_reg.tn[NW-1] != s3_reg.det[NW-1];
        s4_next.neg_u = s3_reg.un[NW-1] != s3_reg.det[NW-1];
        // magnitude of two or more never fits the window
        s4_next.oor_t = DW'(amt) >= {ad, 1'b0};
        s4_next.oor_u = DW'(amu) >= {ad, 1'b0};
        // zero determinant is parallel even with a zero epsilon
        s4_next.par   = (ad == '0) || (ad < NW'(eps_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_reg <= s4_next;
        end
    end

    // ---------------- stages 4..20: restoring divider, one quotient bit each
    div_t div_reg [NDIV];
    div_t div_next [NDIV];

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        if (g == 0)
        begin : g_first
            lsi_div_step #(.SHIFT(1'b0)) u_step (
                .cur (s4_reg),
                .nxt (div_next[g])
            );
        end
        else
        begin : g_rest
            lsi_div_step #(.SHIFT(1'b1)) u_step (
                .cur (div_reg[g-1]),
                .nxt (div_next[g])
            );
        end

        always_ff @(posedge clk)
        begin
            if (en[4+g])
            begin
                div_reg[g] <= div_next[g];
            end
        end
    end

    // ---------------- stage 21: window test and t times direction
    pt_t  pt_reg;
    pt_t  pt_next;
    div_t dl;
    logic t_neg;
    logic u_neg;
    logic t_ok;
    logic u_ok;
    logic [DFW-1:0] adx;
    logic [DFW-1:0] ady;

    always_comb
    begin
        dl    = div_reg[NDIV-1];
        // a quotient that truncates to zero counts as positive
        t_neg = dl.neg_t && (dl.qt != '0);
        u_neg = dl.neg_u && (dl.qu != '0);
        t_ok  = !dl.oor_t && (t_neg ? (dl.qt <= QW'(tol_reg))
                : ({1'b0, dl.qt} <= (QW+1)'(1 << PF) + (QW+1)'(tol_reg)));
        u_ok  = !dl.oor_u && (u_neg ? (dl.qu <= QW'(tol_reg))
                : ({1'b0, dl.qu} <= (QW+1)'(1 << PF) + (QW+1)'(tol_reg)));
        adx   = dl.dax[DFW-1] ? DFW'(-dl.dax) : DFW'(dl.dax);
        ady   = dl.day[DFW-1] ? DFW'(-dl.day) : DFW'(dl.day);
        pt_next.x1 = dl.x1;
        pt_next.y1 = dl.y1;
        pt_next.px = MPW'(dl.qt) * MPW'(adx);
        pt_next.py = MPW'(dl.qt) * MPW'(ady);
        pt_next.sx = t_neg != dl.dax[DFW-1];
        pt_next.sy = t_neg != dl.day[DFW-1];
        if (dl.par)
        begin
            pt_next.outcome = OUT_PARALLEL;
        end
        else if (!t_ok || !u_ok)
        begin
            pt_next.outcome = OUT_OUTSIDE;
        end
        else
        begin
            pt_next.outcome = OUT_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SPT])
        begin
            pt_reg <= pt_next;
        end
    end

    // ---------------- stage 22: truncate, add start point, saturate
    seg_out_t out_reg;
    seg_out_t out_next;
    logic signed [SW-1:0] vx;
    logic signed [SW-1:0] vy;
    logic [SW-1:0] dx;
    logic [SW-1:0] dy;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if ((v[SW-1:CW-1] == '0) || (v[SW-1:CW-1] == '1))
        begin
            r = v[CW-1:0];
        end
        else if (v[SW-1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        dx = SW'(pt_reg.px[MPW-1:PF]);
        dy = SW'(pt_reg.py[MPW-1:PF]);
        vx = SW'(pt_reg.x1) + $signed(pt_reg.sx ? -dx : dx);
        vy = SW'(pt_reg.y1) + $signed(pt_reg.sy ? -dy : dy);
        out_next.outcome = pt_reg.outcome;
        if (pt_reg.outcome == OUT_HIT)
        begin
            out_next.cross_x = sat_coord(vx);
            out_next.cross_y = sat_coord(vy);
        end
        else
        begin
            out_next.cross_x = '0;
            out_next.cross_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SOUT])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/core/lsi_div_step.sv
// ----------------------------------------------------------------------------
// lsi_div_step
// one restoring division step for the t and u lanes
// ----------------------------------------------------------------------------
module lsi_div_step
    import lsi_pkg::*;
#(
    parameter bit SHIFT = 1'b1
)(
    input  div_t cur,
    output div_t nxt
);

    logic [DW-1:0] rt_s;
    logic [DW-1:0] ru_s;
    logic [QW-1:0] qt_s;
    logic [QW-1:0] qu_s;

    always_comb
    begin
        // integer step has no shift
        rt_s = SHIFT ? {cur.rt[DW-2:0], 1'b0} : cur.rt;
        ru_s = SHIFT ? {cur.ru[DW-2:0], 1'b0} : cur.ru;
        qt_s = SHIFT ? {cur.qt[QW-2:0], 1'b0} : cur.qt;
        qu_s = SHIFT ? {cur.qu[QW-2:0], 1'b0} : cur.qu;
        nxt = cur;
        if (rt_s >= cur.d)
        begin
            nxt.rt = rt_s - cur.d;
            nxt.qt = qt_s | QW'(1);
        end
        else
        begin
            nxt.rt = rt_s;
            nxt.qt = qt_s;
        end
        if (ru_s >= cur.d)
        begin
            nxt.ru = ru_s - cur.d;
            nxt.qu = qu_s | QW'(1);
        end
        else
        begin
            nxt.ru = ru_s;
            nxt.qu = qu_s;
        end
    end

endmodule

FILE: rtl/core/lsi_checker.sv
// ----------------------------------------------------------------------------
// lsi_port_checks
// port-level checks on the segment intersection output channel
// ----------------------------------------------------------------------------
module lsi_port_checks
    import lsi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input seg_out_t out_data
);

    // a waiting output beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output beat changed while stalled");

    // coordinates only on a hit
    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome != OUT_HIT)
        |-> (out_data.cross_x == '0) && (out_data.cross_y == '0))
        else $error("coordinates set without a hit");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.outcome == OUT_HIT) ||
            (out_data.outcome == OUT_PARALLEL) || (out_data.outcome == OUT_OUTSIDE))
        else $error("undefined outcome code");

    // an empty output stage never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind line_segment_intersection_top lsi_port_checks u_lsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: tb/sv/lsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsi_checker
// watches the input and output channels of the segment intersection block,
// predicts each result from the accepted segment pair and the current
// register values, and counts mismatches against the results it sees
// ----------------------------------------------------------------------------
module lsi_checker
    import lsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  seg_in_t           in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  seg_out_t          out_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [EPSW-1:0]   cfg_data,
    output int                fail_count,
    output int                pending,
    output int                hit_count,
    output int                par_count,
    output int                outside_count
);

    seg_out_t          expected_q[$];
    logic [EPSW-1:0]   eps_r;
    logic [TOLW-1:0]   tol_r;
    int                shown;

    // quotient num/den with 16 fraction bits, truncated; 0 when out of range
    function automatic bit param_ok(input logic signed [127:0] num,
                                    input logic signed [127:0] den,
                                    output logic signed [63:0] q_out);
        logic [127:0] m;
        logic [127:0] d;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        m = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q_out = 0;
        if (m >= (d << 1))
            return 0;
        q = (m << PF) / d;
        if (neg && q != 0)
        begin
            q_out = -$signed({1'b0, q[62:0]});
            return q <= tol_r;
        end
        q_out = $signed({1'b0, q[62:0]});
        return q <= (128'd1 << PF) + tol_r;
    endfunction

    function automatic logic signed [CW-1:0] point_at(input longint p, input longint d,
                                                      input longint t);
        longint mt;
        longint md;
        longint prod;
        longint v;
        mt = (t < 0) ? -t : t;
        md = (d < 0) ? -d : d;
        prod = (mt * md) >>> PF;
        v = p + (((t < 0) != (d < 0)) ? -prod : prod);
        if (v > (64'sd1 << (CW - 1)) - 1)
            v = (64'sd1 << (CW - 1)) - 1;
        if (v < -(64'sd1 << (CW - 1)))
            v = -(64'sd1 << (CW - 1));
        return v[CW-1:0];
    endfunction

    function automatic seg_out_t predict_crossing(input seg_in_t s);
        seg_out_t r;
        longint x1, y1, x3, y3, dax, day, dbx, dby, ox, oy;
        logic signed [127:0] det, tn, un, adet;
        logic signed [63:0] t, u;
        bit t_ok, u_ok;
        x1 = s.a_start_x;
        y1 = s.a_start_y;
        x3 = s.b_start_x;
        y3 = s.b_start_y;
        dax = longint'(s.a_end_x) - x1;
        day = longint'(s.a_end_y) - y1;
        dbx = longint'(s.b_end_x) - x3;
        dby = longint'(s.b_end_y) - y3;
        ox = x1 - x3;
        oy = y1 - y3;
        det = 128'(dby) * 128'(dax) - 128'(dbx) * 128'(day);
        tn = 128'(dbx) * 128'(oy) - 128'(dby) * 128'(ox);
        un = 128'(dax) * 128'(oy) - 128'(day) * 128'(ox);
        adet = (det < 0) ? -det : det;
        r = '0;
        if (adet == 0 || adet < $signed({96'd0, eps_r}))
        begin
            r.outcome = OUT_PARALLEL;
            return r;
        end
        t_ok = param_ok(tn, det, t);
        u_ok = param_ok(un, det, u);
        if (!t_ok || !u_ok)
        begin
            r.outcome = OUT_OUTSIDE;
            return r;
        end
        r.outcome = OUT_HIT;
        r.cross_x = point_at(x1, dax, t);
        r.cross_y = point_at(y1, day, t);
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_r <= 32'd1;
            tol_r <= 16'd6554;
            fail_count <= 0;
            hit_count <= 0;
            par_count <= 0;
            outside_count <= 0;
            shown <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DET_EPS)
                eps_r <= cfg_data;
            else if (cfg_we && cfg_index == CFG_PARAM_TOL)
                tol_r <= cfg_data[TOLW-1:0];
            if (in_valid && in_ready)
                expected_q.push_back(predict_crossing(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (shown < 10)
                        $display("unexpected result beat %p", out_data);
                    shown <= shown + 1;
                end
                else
                begin
                    seg_out_t e;
                    e = expected_q.pop_front();
                    if (e.outcome == OUT_HIT)
                        hit_count <= hit_count + 1;
                    else if (e.outcome == OUT_PARALLEL)
                        par_count <= par_count + 1;
                    else
                        outside_count <= outside_count + 1;
                    if (e.outcome !== out_data.outcome || e.cross_x !== out_data.cross_x
                        || e.cross_y !== out_data.cross_y)
                    begin
                        fail_count <= fail_count + 1;
                        if (shown < 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     e.outcome, e.cross_x, e.cross_y, out_data.outcome,
                                     out_data.cross_x, out_data.cross_y);
                        shown <= shown + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_line_segment_intersection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_intersection_top
// drives segment pairs with bursty valid and a stalling receiver through
// several epsilon and tolerance settings; a checker beside the block predicts
// and compares every result beat
// ----------------------------------------------------------------------------
module tb_line_segment_intersection_top;
    import lsi_pkg::*;

    localparam int LATENCY = 23;
    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    seg_in_t           in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    seg_out_t          out_data;
    logic              cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = CFG_DET_EPS;
    logic [EPSW-1:0]   cfg_data = '0;
    int                fail_count, pending, hit_count, par_count, outside_count;
    int                idle_cycles = 0;
    int                sent = 0;
    bit                timed_out = 1'b0;

    always #1 clk = ~clk;

    line_segment_intersection_top i_dut (.*);

    lsi_checker i_checker (.*);

    // receiver stalls in its own pattern: long ready runs, bursts of stall
    always @(negedge clk)
    begin
        int mode;
        mode = (sent / 300) % 3;
        if (mode == 0)
            out_ready <= 1'b1;
        else if (mode == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 1) != 0);
    end

    // watchdog on cycles with no accepted beat on either channel and no register write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb_line_segment_intersection_top failed");
            $finish;
        end
    end

    // one beat, held until accepted
    task automatic send_pair(input seg_in_t s);
        in_data <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // wait for every expected beat plus the pipeline depth, then write a register
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [EPSW-1:0] val);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int scale);
        logic [31:0] r;
        r = $urandom;
        case (scale)
            0: return $signed(CW'($signed(r[11:0])));
            1: return $signed(CW'($signed(r[17:0])));
            default: return r[CW-1:0];
        endcase
    endfunction

    function automatic seg_in_t pack_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
        seg_in_t s;
        s.a_start_x = CW'(ax); s.a_start_y = CW'(ay);
        s.a_end_x = CW'(bx); s.a_end_y = CW'(by);
        s.b_start_x = CW'(cx); s.b_start_y = CW'(cy);
        s.b_end_x = CW'(dx); s.b_end_y = CW'(dy);
        return s;
    endfunction

    // mostly crossing segments built around a point, some parallel copies, the rest noise
    function automatic seg_in_t random_pair();
        seg_in_t s;
        int scale, kind;
        logic signed [CW-1:0] px, py;
        scale = $urandom_range(0, 9) < 7 ? $urandom_range(0, 1) : 2;
        kind = $urandom_range(0, 9);
        s = {rand_coord(scale), rand_coord(scale), rand_coord(scale), rand_coord(scale),
             rand_coord(scale), rand_coord(scale), rand_coord(scale), rand_coord(scale)};
        if (kind < 6)
        begin
            px = rand_coord(0);
            py = rand_coord(0);
            s.a_end_x = CW'(2 * px - s.a_start_x);
            s.a_end_y = CW'(2 * py - s.a_start_y);
            s.b_end_x = CW'(2 * px - s.b_start_x);
            s.b_end_y = CW'(2 * py - s.b_start_y);
        end
        else if (kind == 6)
        begin
            // parallel copy of segment A
            s.b_end_x = s.b_start_x + (s.a_end_x - s.a_start_x);
            s.b_end_y = s.b_start_y + (s.a_end_y - s.a_start_y);
        end
        return s;
    endfunction

    task automatic random_phase(input int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0)
            begin
                send_pair(random_pair());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: crossing, touching ends, parallel, degenerate, extremes
        send_pair(pack_pair(0, 0, 256, 256, 0, 256, 256, 0));
        send_pair(pack_pair(0, 0, 256, 0, 256, 0, 256, 256));
        send_pair(pack_pair(0, 0, 256, 0, 0, 256, 256, 256));
        send_pair(pack_pair(0, 0, 256, 256, 0, 0, 512, 512));
        send_pair(pack_pair(5, 5, 5, 5, 0, 256, 256, 0));
        send_pair(pack_pair(0, 0, 256, 0, 1024, -256, 1024, 256));
        send_pair(pack_pair(0, 0, 256, 0, -10, -256, -10, 256));
        send_pair(pack_pair(0, 0, 256, 0, 270, -256, 270, 256));
        send_pair(pack_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_pair(pack_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
        send_pair(pack_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
        send_pair(pack_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN));
        send_pair(pack_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        send_pair(pack_pair(0, 0, 3, 0, 1, -1, 1, 1));
        send_pair(pack_pair(-1, 0, 0, 1, 0, 0, 1, 1));
        send_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));

        // hold off until the pipe drains
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        random_phase(500);

        write_reg(CFG_DET_EPS, 32'd0);
        write_reg(CFG_PARAM_TOL, 32'd0);
        send_pair(pack_pair(0, 0, 256, 0, 0, -256, 0, 256));
        random_phase(400);

        write_reg(CFG_DET_EPS, 32'hFFFF_FFFF);
        write_reg(CFG_PARAM_TOL, 32'h0000_FFFF);
        random_phase(200);

        write_reg(CFG_DET_EPS, $urandom_range(2, 5000000));
        write_reg(CFG_PARAM_TOL, $urandom);
        random_phase(400);

        write_reg(CFG_DET_EPS, 32'd1);
        write_reg(CFG_PARAM_TOL, 32'd6554);
        random_phase(300);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);

        $display("sent %0d segment pairs over five register settings", sent);
        $display("results: %0d hits, %0d parallel, %0d outside",
                 hit_count, par_count, outside_count);
        if (fail_count == 0)
            $display("tb_line_segment_intersection_top passed");
        else
            $display("tb_line_segment_intersection_top failed");
        $finish;
    end

endmodule
